@@ rtl/pld_pkg.sv @@
`default_nettype none
package pld_pkg;

  // grid and arithmetic sizing
  localparam int MAX_ROWS   = 256;
  localparam int MAX_COLS   = 256;
  localparam int VALUE_BITS = 32;
  localparam int SAT_BITS   = (VALUE_BITS > 32) ? 32 : VALUE_BITS;

  localparam int ROW_BITS     = 8;
  localparam int COL_BITS     = 8;
  localparam int ROW_CNT_BITS = $clog2(MAX_ROWS + 1);
  localparam int COL_CNT_BITS = $clog2(MAX_COLS + 1);
  localparam int CELLS        = MAX_ROWS * MAX_COLS;
  localparam int ADDR_BITS    = $clog2(CELLS);
  localparam int DATA_BITS    = 32;
  localparam int SIZE_BITS    = 9;
  localparam int SCALE_BITS   = 32;
  localparam int HALF_BITS    = SCALE_BITS / 2;
  localparam int MIN_SIZE     = 3;

  // stencil sums: at most 40 * 2^31 in magnitude
  localparam int ACC_BITS  = 38;
  localparam int PROD_BITS = ACC_BITS + HALF_BITS;
  localparam int Q_BITS    = PROD_BITS + 1;
  localparam int RES_BITS  = 32;

  localparam logic [Q_BITS-1:0] ROUND_HALF = Q_BITS'(1) << (HALF_BITS - 1);
  localparam logic [Q_BITS-1:0] PMAX       = (Q_BITS'(1) << (SAT_BITS - 1)) - Q_BITS'(1);
  localparam logic [Q_BITS-1:0] NMAG       = PMAX + Q_BITS'(1);
  localparam logic [RES_BITS-1:0] RES_PMAX = RES_BITS'(PMAX);
  localparam logic [RES_BITS-1:0] RES_NMIN = RES_BITS'(Q_BITS'(0) - NMAG);

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROWS      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLS      = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LAP_SCALE = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DIV_SCALE = 2'd3;

  localparam logic [SIZE_BITS-1:0]  ROWS_RESET      = 9'd256;
  localparam logic [SIZE_BITS-1:0]  COLS_RESET      = 9'd256;
  localparam logic [SCALE_BITS-1:0] LAP_SCALE_RESET = 32'd174763;
  localparam logic [SCALE_BITS-1:0] DIV_SCALE_RESET = 32'd21845;

  // codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SAT   = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic                        action;
    logic [ROW_BITS-1:0]         row;
    logic [COL_BITS-1:0]         col;
    logic signed [DATA_BITS-1:0] scalar_value;
    logic signed [DATA_BITS-1:0] vec_x;
    logic signed [DATA_BITS-1:0] vec_y;
  } req_t;

  typedef struct packed {
    logic [ROW_BITS-1:0]        out_row;
    logic [COL_BITS-1:0]        out_col;
    logic signed [RES_BITS-1:0] laplacian;
    logic signed [RES_BITS-1:0] divergence;
    logic [1:0]                 status;
  } rsp_t;

  // result of one pass through the scaling unit
  typedef struct packed {
    logic                       done;
    logic                       sat;
    logic signed [RES_BITS-1:0] value;
  } sc_res_t;

  // neighbour read order
  typedef enum logic [3:0] {
    NB_C, NB_N, NB_S, NB_E, NB_W, NB_NE, NB_NW, NB_SE, NB_SW
  } nb_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_LAP_GO, ST_LAP_WAIT, ST_DIV_WAIT, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    SC_IDLE, SC_HI, SC_LO, SC_ADD, SC_SAT
  } sc_state_t;

  function automatic logic [ADDR_BITS-1:0] cell_addr(
    input logic [ROW_BITS-1:0] row,
    input logic [COL_BITS-1:0] col
  );
    cell_addr = ADDR_BITS'(row) * ADDR_BITS'(MAX_COLS) + ADDR_BITS'(col);
  endfunction

endpackage
`default_nettype wire

@@ rtl/pld_ram.sv @@
`default_nettype none
module pld_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/pld_scale.sv @@
`default_nettype none
module pld_scale (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [pld_pkg::ACC_BITS-1:0]  sum,
  input  logic [pld_pkg::SCALE_BITS-1:0]       scale,
  output pld_pkg::sc_res_t                     res
);
  import pld_pkg::*;

  sc_state_t state, state_next;

  logic                   neg;
  logic [ACC_BITS-1:0]    mag;
  logic [SCALE_BITS-1:0]  scale_q;
  logic [HALF_BITS-1:0]   mul_b;
  logic [PROD_BITS-1:0]   mul_out;
  logic [PROD_BITS-1:0]   prod_hi;
  logic [PROD_BITS-1:0]   prod_lo;
  logic [Q_BITS-1:0]      q;
  logic                   sat_next;
  logic [RES_BITS-1:0]    value_next;
  logic                   done_q;
  logic                   sat_q;
  logic signed [RES_BITS-1:0] value_q;

  assign res = '{done: done_q, sat: sat_q, value: value_q};

  // one multiplier, used for the upper then the lower half of the scale
  assign mul_b   = (state == SC_HI) ? scale_q[SCALE_BITS-1:HALF_BITS]
                                    : scale_q[HALF_BITS-1:0];
  assign mul_out = PROD_BITS'(mag) * PROD_BITS'(mul_b);

  always_comb begin
    state_next = state;
    case (state)
      SC_IDLE: if (start) state_next = SC_HI;
      SC_HI:   state_next = SC_LO;
      SC_LO:   state_next = SC_ADD;
      SC_ADD:  state_next = SC_SAT;
      SC_SAT:  state_next = SC_IDLE;
      default: state_next = SC_IDLE;
    endcase
  end

  // round-to-nearest magnitude, then clip to the signed range
  always_comb begin
    sat_next   = 1'b0;
    value_next = RES_BITS'(q);
    if (neg) begin
      if (q > NMAG) begin
        sat_next   = 1'b1;
        value_next = RES_NMIN;
      end else begin
        value_next = RES_BITS'(Q_BITS'(0) - q);
      end
    end else if (q > PMAX) begin
      sat_next   = 1'b1;
      value_next = RES_PMAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SC_IDLE;
      done_q <= 1'b0;
    end else begin
      state  <= state_next;
      done_q <= (state == SC_SAT);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SC_IDLE: begin
        if (start) begin
          neg     <= sum[ACC_BITS-1];
          mag     <= sum[ACC_BITS-1] ? ACC_BITS'(-sum) : ACC_BITS'(sum);
          scale_q <= scale;
        end
      end
      SC_HI:  prod_hi <= mul_out;
      SC_LO:  prod_lo <= mul_out;
      SC_ADD: q <= Q_BITS'(prod_hi) + ((Q_BITS'(prod_lo) + ROUND_HALF) >> HALF_BITS);
      SC_SAT: begin
        sat_q   <= sat_next;
        value_q <= value_next;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/periodic_laplacian_divergence_stencil.sv @@
`default_nettype none
// Periodic nine-point stencil engine. The block holds a wrap-around 2D grid
// (up to 256 x 256 cells) of a Q16.16 scalar field and a Q16.16 vector field
// in three single-port-read memories. A write beat stores one cell's three
// values, and the block is ready again on the next cycle. A query beat
// returns the isotropic Laplacian (4*edges - 20*centre + diagonals, times
// lap_scale) and the isotropic divergence (times div_scale) of one cell,
// each rounded to nearest and saturated to 32 bits, with status 1 if either
// result clipped. After accepting a query the block reads the nine
// neighbours through the one read port of each memory, one neighbour a
// cycle, launches scaling, makes the two passes through the shared scaling
// multiplier, waits while a stalled result still holds the result
// register, then loads it and is ready again. A query outside the grid in
// use goes straight to loading the result register and returns status 2
// with zero results; a write outside the grid is dropped. The grid size
// registers are clamped to 3..256 when used. Cells must be written before
// any query that reads them; the memories are not cleared after reset.
// Configuration is to be written only while the block is idle; the block
// itself does not enforce this.
module periodic_laplacian_divergence_stencil (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                req_valid,
  output logic                                req_stall,
  input  pld_pkg::req_t                       req,
  // response channel
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output pld_pkg::rsp_t                       rsp,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [pld_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pld_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import pld_pkg::*;

  // configuration registers
  logic [SIZE_BITS-1:0]  rows_in_use;
  logic [SIZE_BITS-1:0]  cols_in_use;
  logic [SCALE_BITS-1:0] lap_scale;
  logic [SCALE_BITS-1:0] div_scale;

  // clamped grid size
  logic [ROW_CNT_BITS-1:0] nr;
  logic [COL_CNT_BITS-1:0] nc;

  // request decode
  logic                    accept;
  logic                    on_grid;
  logic                    mem_we;
  logic [ROW_CNT_BITS-1:0] row_inc;
  logic [COL_CNT_BITS-1:0] col_inc;
  logic [ROW_BITS-1:0]     row_p_next, row_m_next;
  logic [COL_BITS-1:0]     col_p_next, col_m_next;

  // held query coordinates and wrapped neighbours
  logic [ROW_BITS-1:0] cur_row, row_p, row_m;
  logic [COL_BITS-1:0] cur_col, col_p, col_m;

  // read sequencer
  state_t              state, state_next;
  logic                issuing, taking;
  nb_t                 issue, take_nb;
  logic [ROW_BITS-1:0] sel_row;
  logic [COL_BITS-1:0] sel_col;
  logic [ADDR_BITS-1:0] waddr, raddr;

  // memory read data
  logic signed [DATA_BITS-1:0] rd_f, rd_vx, rd_vy;
  logic signed [ACC_BITS-1:0]  fe, vxe, vye;
  logic signed [ACC_BITS-1:0]  lap_term, div_term;
  logic signed [ACC_BITS-1:0]  lap_acc, div_acc;

  // shared scaling unit
  logic                       sc_start;
  logic                       sc_pick_div;
  logic signed [ACC_BITS-1:0] sc_sum;
  logic [SCALE_BITS-1:0]      sc_scale;
  sc_res_t                    sc_res;

  // results waiting for the response register
  logic signed [RES_BITS-1:0] res_lap, res_div;
  logic                       res_sat, res_range;
  logic                       rsp_load;

  // ---------------------------------------------------------------------------
  // grid size clamp to 3..MAX
  // ---------------------------------------------------------------------------
  always_comb begin
    if (rows_in_use < SIZE_BITS'(MIN_SIZE)) begin
      nr = ROW_CNT_BITS'(MIN_SIZE);
    end else if (32'(rows_in_use) > 32'(MAX_ROWS)) begin
      nr = ROW_CNT_BITS'(MAX_ROWS);
    end else begin
      nr = ROW_CNT_BITS'(rows_in_use);
    end
    if (cols_in_use < SIZE_BITS'(MIN_SIZE)) begin
      nc = COL_CNT_BITS'(MIN_SIZE);
    end else if (32'(cols_in_use) > 32'(MAX_COLS)) begin
      nc = COL_CNT_BITS'(MAX_COLS);
    end else begin
      nc = COL_CNT_BITS'(cols_in_use);
    end
  end

  assign on_grid = (ROW_CNT_BITS'(req.row) < nr) && (COL_CNT_BITS'(req.col) < nc);

  // wrap-around neighbours of the requested cell
  assign row_inc    = ROW_CNT_BITS'(req.row) + ROW_CNT_BITS'(1);
  assign col_inc    = COL_CNT_BITS'(req.col) + COL_CNT_BITS'(1);
  assign row_p_next = (row_inc == nr) ? '0 : ROW_BITS'(row_inc);
  assign col_p_next = (col_inc == nc) ? '0 : COL_BITS'(col_inc);
  assign row_m_next = (req.row == '0) ? ROW_BITS'(nr - ROW_CNT_BITS'(1))
                                      : req.row - ROW_BITS'(1);
  assign col_m_next = (req.col == '0) ? COL_BITS'(nc - COL_CNT_BITS'(1))
                                      : req.col - COL_BITS'(1);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next  = state;
    req_stall   = 1'b1;
    mem_we      = 1'b0;
    sc_start    = 1'b0;
    sc_pick_div = 1'b0;
    rsp_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          if (req.action == ACT_WRITE) begin
            mem_we = on_grid;
          end else begin
            state_next = on_grid ? ST_READ : ST_DONE;
          end
        end
      end
      ST_READ: begin
        // last neighbour lands in the accumulators this cycle
        if (taking && (take_nb == NB_SW)) state_next = ST_LAP_GO;
      end
      ST_LAP_GO: begin
        sc_start   = 1'b1;
        state_next = ST_LAP_WAIT;
      end
      ST_LAP_WAIT: begin
        if (sc_res.done) begin
          sc_start    = 1'b1;
          sc_pick_div = 1'b1;
          state_next  = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (sc_res.done) state_next = ST_DONE;
      end
      ST_DONE: begin
        // wait for the response register to free up
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept = req_valid && !req_stall;

  // neighbour address for the read issued this cycle
  always_comb begin
    sel_row = cur_row;
    sel_col = cur_col;
    case (issue)
      NB_C:  begin sel_row = cur_row; sel_col = cur_col; end
      NB_N:  begin sel_row = row_p;   sel_col = cur_col; end
      NB_S:  begin sel_row = row_m;   sel_col = cur_col; end
      NB_E:  begin sel_row = cur_row; sel_col = col_p;   end
      NB_W:  begin sel_row = cur_row; sel_col = col_m;   end
      NB_NE: begin sel_row = row_p;   sel_col = col_p;   end
      NB_NW: begin sel_row = row_p;   sel_col = col_m;   end
      NB_SE: begin sel_row = row_m;   sel_col = col_p;   end
      NB_SW: begin sel_row = row_m;   sel_col = col_m;   end
      default: begin sel_row = cur_row; sel_col = cur_col; end
    endcase
  end

  assign waddr = cell_addr(req.row, req.col);
  assign raddr = cell_addr(sel_row, sel_col);

  // ---------------------------------------------------------------------------
  // field stores
  // ---------------------------------------------------------------------------
  pld_ram #(.WIDTH(DATA_BITS), .DEPTH(CELLS)) u_scalar_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (req.scalar_value),
    .raddr (raddr),
    .rdata (rd_f)
  );

  pld_ram #(.WIDTH(DATA_BITS), .DEPTH(CELLS)) u_vecx_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (req.vec_x),
    .raddr (raddr),
    .rdata (rd_vx)
  );

  pld_ram #(.WIDTH(DATA_BITS), .DEPTH(CELLS)) u_vecy_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (req.vec_y),
    .raddr (raddr),
    .rdata (rd_vy)
  );

  // ---------------------------------------------------------------------------
  // stencil weights, applied one neighbour a cycle
  // ---------------------------------------------------------------------------
  assign fe  = ACC_BITS'(rd_f);
  assign vxe = ACC_BITS'(rd_vx);
  assign vye = ACC_BITS'(rd_vy);

  always_comb begin
    lap_term = '0;
    div_term = '0;
    case (take_nb)
      // centre weighs -20 = -(16 + 4)
      NB_C:  lap_term = -(fe <<< 4) - (fe <<< 2);
      NB_N:  begin lap_term = fe <<< 2; div_term = vxe <<< 2;    end
      NB_S:  begin lap_term = fe <<< 2; div_term = -(vxe <<< 2); end
      NB_E:  begin lap_term = fe <<< 2; div_term = vye <<< 2;    end
      NB_W:  begin lap_term = fe <<< 2; div_term = -(vye <<< 2); end
      NB_NE: begin lap_term = fe;       div_term = vxe + vye;    end
      NB_NW: begin lap_term = fe;       div_term = vxe - vye;    end
      NB_SE: begin lap_term = fe;       div_term = vye - vxe;    end
      NB_SW: begin lap_term = fe;       div_term = -vxe - vye;   end
      default: begin lap_term = '0; div_term = '0; end
    endcase
  end

  // ---------------------------------------------------------------------------
  // scaling: laplacian pass first, then divergence
  // ---------------------------------------------------------------------------
  assign sc_sum   = sc_pick_div ? div_acc : lap_acc;
  assign sc_scale = sc_pick_div ? div_scale : lap_scale;

  pld_scale u_scale (
    .clk   (clk),
    .rst   (rst),
    .start (sc_start),
    .sum   (sc_sum),
    .scale (sc_scale),
    .res   (sc_res)
  );

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      issuing     <= 1'b0;
      taking      <= 1'b0;
      rsp_valid   <= 1'b0;
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
      lap_scale   <= LAP_SCALE_RESET;
      div_scale   <= DIV_SCALE_RESET;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS:      rows_in_use <= cfg_data[SIZE_BITS-1:0];
          CFG_COLS:      cols_in_use <= cfg_data[SIZE_BITS-1:0];
          CFG_LAP_SCALE: lap_scale   <= cfg_data[SCALE_BITS-1:0];
          CFG_DIV_SCALE: div_scale   <= cfg_data[SCALE_BITS-1:0];
          default: ;
        endcase
      end

      // nine reads in a row, each read's data arriving in the next cycle
      if (accept && (req.action == ACT_QUERY) && on_grid) begin
        issuing <= 1'b1;
      end else if (issuing && (issue == NB_SW)) begin
        issuing <= 1'b0;
      end
      taking <= issuing;

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_row   <= req.row;
      cur_col   <= req.col;
      row_p     <= row_p_next;
      row_m     <= row_m_next;
      col_p     <= col_p_next;
      col_m     <= col_m_next;
      issue     <= NB_C;
      lap_acc   <= '0;
      div_acc   <= '0;
      res_lap   <= '0;
      res_div   <= '0;
      res_sat   <= 1'b0;
      res_range <= !on_grid;
    end else begin
      if (issuing && (issue != NB_SW)) begin
        issue <= nb_t'(issue + 4'd1);
      end
      if (taking) begin
        lap_acc <= lap_acc + lap_term;
        div_acc <= div_acc + div_term;
      end
      if ((state == ST_LAP_WAIT) && sc_res.done) begin
        res_lap <= sc_res.value;
        res_sat <= sc_res.sat;
      end
      if ((state == ST_DIV_WAIT) && sc_res.done) begin
        res_div <= sc_res.value;
        res_sat <= res_sat | sc_res.sat;
      end
    end
    take_nb <= issue;

    if (rsp_load) begin
      rsp.out_row    <= cur_row;
      rsp.out_col    <= cur_col;
      rsp.laplacian  <= res_lap;
      rsp.divergence <= res_div;
      rsp.status     <= res_range ? STATUS_RANGE : (res_sat ? STATUS_SAT : STATUS_OK);
    end
  end

endmodule
`default_nettype wire

@@ rtl/pld_check.sv @@
`default_nettype none
module pld_check (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input pld_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input pld_pkg::rsp_t rsp
);
  import pld_pkg::*;

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response beat changed while stalled");

  // a query occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req.action == ACT_QUERY) |=> req_stall)
    else $error("request taken while a query is in progress");

  // a write leaves the block free again on the next cycle
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req.action == ACT_WRITE) |=> !req_stall)
    else $error("block busy after a write");

  // out-of-range queries carry zero results
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == STATUS_RANGE) |-> (rsp.laplacian == '0) && (rsp.divergence == '0))
    else $error("out-of-range response with nonzero results");

  // a new response only comes out of a busy sequence
  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response appeared without a query in progress");

endmodule

bind periodic_laplacian_divergence_stencil pld_check u_pld_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
`default_nettype wire
